// File: hdl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// shared types and constants for the hue / saturation / lightness adjuster
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SHIFT_W    = 14;
    localparam int GAIN_W     = 16;
    localparam int DIV_W      = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_SHIFT   = 2'd0,
        CFG_SAT_GAIN    = 2'd1,
        CFG_LIGHT_SHIFT = 2'd2
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] SAT_GAIN_RST = 16'd4096;

    // hue segment of one output channel
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_HIGH = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } t_seg;

endpackage

// File: hdl/hsl_front.sv
// ----------------------------------------------------------------------------
// hsl_front
// min / max analysis of one pixel, builds the lightness sum and the dividend
// and divisor of the saturation and hue quotients
// ----------------------------------------------------------------------------
module hsl_front (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [hsl_pkg::CHAN_W-1:0]    i_red,
    input  logic [hsl_pkg::CHAN_W-1:0]    i_green,
    input  logic [hsl_pkg::CHAN_W-1:0]    i_blue,
    output logic [hsl_pkg::DIV_W-1:0]     o_l_num,
    output logic [hsl_pkg::DIV_W-1:0]     o_s_num,
    output logic [hsl_pkg::DIV_W-1:0]     o_s_den,
    output logic [hsl_pkg::DIV_W-1:0]     o_h_num,
    output logic [hsl_pkg::DIV_W-1:0]     o_h_den
);

    localparam int W = hsl_pkg::DIV_W;

    logic [W-1:0] r11, g11, b11, mx, mn, dl, sum, den, d6raw, d6, six;

    logic [W-1:0] r_l_num, r_s_num, r_s_den, r_h_num, r_h_den;

    always_comb begin
        r11 = W'(i_red);
        g11 = W'(i_green);
        b11 = W'(i_blue);
        mx = r11;
        if (g11 > mx) mx = g11;
        if (b11 > mx) mx = b11;
        mn = r11;
        if (g11 < mn) mn = g11;
        if (b11 < mn) mn = b11;
        dl = mx - mn;
        sum = mx + mn;
        den = (sum > W'(255)) ? (W'(510) - sum) : sum;
        if (den == '0) den = W'(1);
        d6raw = (dl << 2) + (dl << 1);
        d6 = (dl == '0) ? W'(1) : d6raw;
        if (mx == r11) begin
            six = (g11 >= b11) ? (g11 - b11) : (d6raw - (b11 - g11));
        end else if (mx == g11) begin
            six = (dl << 1) + b11 - r11;
        end else begin
            six = (dl << 2) + r11 - g11;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l_num <= sum;
            r_s_num <= dl;
            r_s_den <= den;
            r_h_num <= six;
            r_h_den <= d6;
        end
    end

    assign o_l_num = r_l_num;
    assign o_s_num = r_s_num;
    assign o_s_den = r_s_den;
    assign o_h_num = r_h_num;
    assign o_h_den = r_h_den;

endmodule

// File: hdl/hsl_div.sv
// ----------------------------------------------------------------------------
// hsl_div
// pipelined restoring divider, one quotient bit per stage, gives
// floor(num * 2^FRAC_BITS / den) for num <= den
// ----------------------------------------------------------------------------
module hsl_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic [FRAC_BITS:0]          i_en,
    input  logic [hsl_pkg::DIV_W-1:0]   i_num,
    input  logic [hsl_pkg::DIV_W-1:0]   i_den,
    output logic [FRAC_BITS:0]          o_quo
);

    localparam int W = hsl_pkg::DIV_W;

    logic [W-1:0]         r_rem [FRAC_BITS+1];
    logic [W-1:0]         r_den [FRAC_BITS+1];
    logic [FRAC_BITS:0]   r_quo [FRAC_BITS+1];

    logic ge0;
    assign ge0 = (i_num >= i_den);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= ge0 ? (i_num - i_den) : i_num;
            r_den[0] <= i_den;
            r_quo[0] <= (FRAC_BITS+1)'(ge0);
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
        logic [W:0] sh;
        logic       ge;
        assign sh = {r_rem[k-1], 1'b0};
        assign ge = (sh >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= ge ? W'(sh - {1'b0, r_den[k-1]}) : W'(sh);
                r_den[k] <= r_den[k-1];
                r_quo[k] <= {r_quo[k-1][FRAC_BITS-1:0], ge};
            end
        end
    end

    assign o_quo = r_quo[FRAC_BITS];

endmodule

// File: hdl/hsl_back.sv
// ----------------------------------------------------------------------------
// hsl_back
// applies the hue, saturation and lightness adjustments and converts the
// result back to rgb over five register stages
// ----------------------------------------------------------------------------
module hsl_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic [4:0]                     i_en,
    input  logic [FRAC_BITS:0]             i_h,
    input  logic [FRAC_BITS:0]             i_s,
    input  logic [FRAC_BITS:0]             i_l,
    input  logic [hsl_pkg::SHIFT_W-1:0]    i_hue_shift,
    input  logic [hsl_pkg::GAIN_W-1:0]     i_sat_gain,
    input  logic [hsl_pkg::SHIFT_W-1:0]    i_light_shift,
    output logic [hsl_pkg::CHAN_W-1:0]     o_red,
    output logic [hsl_pkg::CHAN_W-1:0]     o_green,
    output logic [hsl_pkg::CHAN_W-1:0]     o_blue
);

    localparam int F  = FRAC_BITS;
    localparam int SW = hsl_pkg::SHIFT_W;
    localparam longint ONE_L = longint'(1) << F;
    localparam logic [F:0]   ONE    = (F+1)'(ONE_L);
    localparam logic [F-1:0] THIRD  = F'(ONE_L / 3);
    localparam logic [F-1:0] TWO3RD = F'(ONE_L - ONE_L / 3);
    localparam logic signed [F+3:0] LMIN = (F+4)'((ONE_L * 5) / 100);
    localparam logic signed [F+3:0] LMAX = (F+4)'((ONE_L * 95) / 100);
    localparam logic [F+2:0] ONE_X  = (F+3)'(ONE_L);
    localparam logic [F+2:0] FOUR_X = (F+3)'(ONE_L * 4);
    localparam logic [F+1:0] TWO_X  = (F+2)'(ONE_L * 2);

    // adjust
    logic signed [F+3:0] hs_ext, ls_ext, lv;
    logic [F+16:0]       sprod;
    logic [F+4:0]        ssh;
    logic [F-1:0]        r_ah;
    logic [F:0]          r_as, r_al;

    always_comb begin
        hs_ext = $signed({{(F-10){i_hue_shift[SW-1]}}, i_hue_shift}) <<< (F-12);
        ls_ext = $signed({{(F-10){i_light_shift[SW-1]}}, i_light_shift}) <<< (F-12);
        sprod  = (F+17)'(i_s) * (F+17)'(i_sat_gain);
        ssh    = (F+5)'(sprod >> 12);
        lv     = $signed((F+4)'(i_l)) + ls_ext;
        if (lv < LMIN) lv = LMIN;
        if (lv > LMAX) lv = LMAX;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ah <= i_h[F-1:0] + hs_ext[F-1:0];
            r_as <= (ssh > (F+5)'(ONE)) ? ONE : ssh[F:0];
            r_al <= lv[F:0];
        end
    end

    // q term
    logic [2*F+1:0] lsprod;
    logic [F+1:0]   lsh, qv;
    logic [F:0]     r_bq, r_bl;
    logic [F-1:0]   r_bh;
    logic           r_bgrey;

    always_comb begin
        lsprod = (2*F+2)'(r_al) * (2*F+2)'(r_as);
        lsh    = (F+2)'(lsprod >> F);
        if (!r_al[F] && !r_al[F-1]) begin
            qv = (F+2)'(r_al) + lsh;
        end else begin
            qv = (F+2)'(r_al) + (F+2)'(r_as) - lsh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_bq    <= qv[F:0];
            r_bl    <= r_al;
            r_bh    <= r_ah;
            r_bgrey <= (r_as == '0);
        end
    end

    // segment select
    logic [F+1:0] pv;
    logic [F-1:0] tv [3];
    logic [F:0]   r_cp, r_cq, r_cd, r_cl;
    logic [F:0]   r_cf [3];
    hsl_pkg::t_seg r_cm [3];
    logic         r_cgrey;

    assign pv    = {r_bl, 1'b0} - (F+2)'(r_bq);
    assign tv[0] = r_bh + THIRD;
    assign tv[1] = r_bh;
    assign tv[2] = r_bh + TWO3RD;

    // value after multiply
    logic [F:0] r_dv [3];
    logic [hsl_pkg::CHAN_W-1:0] r_out [3];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [F+2:0]  t6;
        logic [F+1:0]  t3;
        logic [F:0]    fv;
        hsl_pkg::t_seg mv;
        logic [2*F+1:0] dprod;
        logic [F+1:0]  vsum;
        logic [F+8:0]  cw;

        always_comb begin
            t6 = ((F+3)'(tv[c]) << 2) + ((F+3)'(tv[c]) << 1);
            t3 = ((F+2)'(tv[c]) << 1) + (F+2)'(tv[c]);
            if (t6 < ONE_X) begin
                mv = hsl_pkg::SEG_RISE;
                fv = t6[F:0];
            end else if (!tv[c][F-1]) begin
                mv = hsl_pkg::SEG_HIGH;
                fv = '0;
            end else if (t3 < TWO_X) begin
                mv = hsl_pkg::SEG_FALL;
                fv = (F+1)'(FOUR_X - t6);
            end else begin
                mv = hsl_pkg::SEG_LOW;
                fv = '0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[2]) begin
                r_cf[c] <= fv;
                r_cm[c] <= mv;
            end
        end

        always_comb begin
            dprod = (2*F+2)'(r_cd) * (2*F+2)'(r_cf[c]);
            vsum  = (F+2)'(r_cp) + (F+2)'(dprod >> F);
        end

        always_ff @(posedge i_clk) begin
            if (i_en[3]) begin
                if (r_cgrey) begin
                    r_dv[c] <= r_cl;
                end else begin
                    case (r_cm[c])
                        hsl_pkg::SEG_HIGH: r_dv[c] <= r_cq;
                        hsl_pkg::SEG_LOW:  r_dv[c] <= r_cp;
                        default:           r_dv[c] <= vsum[F:0];
                    endcase
                end
            end
        end

        assign cw = (((F+9)'(r_dv[c]) << 8) - (F+9)'(r_dv[c])) >> F;

        always_ff @(posedge i_clk) begin
            if (i_en[4]) begin
                r_out[c] <= (cw > (F+9)'(255)) ? 8'd255 : cw[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_cp    <= pv[F:0];
            r_cq    <= r_bq;
            r_cd    <= r_bq - pv[F:0];
            r_cl    <= r_bl;
            r_cgrey <= r_bgrey;
        end
    end

    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule

// File: hdl/hsl_color_adjust.sv
// ----------------------------------------------------------------------------
// hsl_color_adjust
// rgb to hsl, hue / saturation / lightness adjustment, hsl back to rgb
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_stall  | i_red_in, i_green_in, i_blue_in
//   output  | out       | o_valid / i_stall  | o_red_out, o_green_out, o_blue_out
//   config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// one item per cycle while i_stall is low
// most of the stages are in the two dividers, one quotient bit per stage
// each stage holds only while it is full and the stage after it holds
// synchronous active-low reset clears the valid bits and resets the config registers
// ----------------------------------------------------------------------------
module hsl_color_adjust #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [hsl_pkg::CHAN_W-1:0]        i_red_in,
    input  logic [hsl_pkg::CHAN_W-1:0]        i_green_in,
    input  logic [hsl_pkg::CHAN_W-1:0]        i_blue_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [hsl_pkg::CHAN_W-1:0]        o_red_out,
    output logic [hsl_pkg::CHAN_W-1:0]        o_green_out,
    output logic [hsl_pkg::CHAN_W-1:0]        o_blue_out,
    input  logic                              i_cfg_we,
    input  logic [hsl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hsl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int F  = FRAC_BITS;
    localparam int NS = F + 7;
    localparam int LK = 20;
    localparam longint L_RECIP = ((longint'(1) << (F + LK)) + 509) / 510;

    logic [hsl_pkg::SHIFT_W-1:0] r_hue_shift, r_light_shift;
    logic [hsl_pkg::GAIN_W-1:0]  r_sat_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_shift   <= '0;
            r_sat_gain    <= hsl_pkg::SAT_GAIN_RST;
            r_light_shift <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hsl_pkg::CFG_HUE_SHIFT:
                    r_hue_shift <= i_cfg_data[hsl_pkg::SHIFT_W-1:0];
                hsl_pkg::CFG_SAT_GAIN:
                    r_sat_gain <= i_cfg_data[hsl_pkg::GAIN_W-1:0];
                hsl_pkg::CFG_LIGHT_SHIFT:
                    r_light_shift <= i_cfg_data[hsl_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and ready chain
    logic [NS-1:0] r_vld, n_vld;
    logic [NS:0]   rdy;

    always_comb begin
        rdy[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NS-1];

    logic [hsl_pkg::DIV_W-1:0] l_num, s_num, s_den, h_num, h_den;
    logic [F:0]                h_q, s_q, l_q;

    hsl_front u_front (
        .i_clk   (i_clk),
        .i_en    (rdy[0]),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_l_num (l_num),
        .o_s_num (s_num),
        .o_s_den (s_den),
        .o_h_num (h_num),
        .o_h_den (h_den)
    );

    // lightness: sum / 510 by reciprocal multiply, then delayed to the divider depth
    logic [F+LK+1:0] l_prod;
    logic [F:0]      r_l_pipe [F+1];

    assign l_prod = (F+LK+2)'(l_num) * (F+LK+2)'(L_RECIP);

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_l_pipe[0] <= l_prod[F+LK:LK];
        end
    end

    for (genvar k = 1; k <= F; k++) begin : g_l_dly
        always_ff @(posedge i_clk) begin
            if (rdy[k+1]) begin
                r_l_pipe[k] <= r_l_pipe[k-1];
            end
        end
    end

    assign l_q = r_l_pipe[F];

    hsl_div #(.FRAC_BITS(F)) u_div_s (
        .i_clk (i_clk),
        .i_en  (rdy[F+1:1]),
        .i_num (s_num),
        .i_den (s_den),
        .o_quo (s_q)
    );

    hsl_div #(.FRAC_BITS(F)) u_div_h (
        .i_clk (i_clk),
        .i_en  (rdy[F+1:1]),
        .i_num (h_num),
        .i_den (h_den),
        .o_quo (h_q)
    );

    hsl_back #(.FRAC_BITS(F)) u_back (
        .i_clk         (i_clk),
        .i_en          (rdy[F+6:F+2]),
        .i_h           (h_q),
        .i_s           (s_q),
        .i_l           (l_q),
        .i_hue_shift   (r_hue_shift),
        .i_sat_gain    (r_sat_gain),
        .i_light_shift (r_light_shift),
        .o_red         (o_red_out),
        .o_green       (o_green_out),
        .o_blue        (o_blue_out)
    );

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled with a free stage");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item not held in first stage");

    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out)))
        else $error("stalled result lost");

    a_gain_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == hsl_pkg::CFG_SAT_GAIN)
            |=> (r_sat_gain == $past(i_cfg_data)))
        else $error("gain write missed");

endmodule

// File: verif/hsl_color_adjust_chk.sv
// ----------------------------------------------------------------------------
// hsl_color_adjust_chk
// watches both channels and the config port, predicts each adjusted pixel in
// fixed point and compares it field by field with the block's output
// ----------------------------------------------------------------------------
module hsl_color_adjust_chk #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_in_stall,
    input  logic [hsl_pkg::CHAN_W-1:0]     i_red,
    input  logic [hsl_pkg::CHAN_W-1:0]     i_green,
    input  logic [hsl_pkg::CHAN_W-1:0]     i_blue,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [hsl_pkg::CHAN_W-1:0]     i_red_out,
    input  logic [hsl_pkg::CHAN_W-1:0]     i_green_out,
    input  logic [hsl_pkg::CHAN_W-1:0]     i_blue_out,
    input  logic                           i_cfg_we,
    input  logic [hsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hsl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);

    localparam int     CW    = hsl_pkg::CHAN_W;
    localparam int     SW    = hsl_pkg::SHIFT_W;
    localparam longint ONE   = longint'(1) << FRAC_BITS;
    localparam longint MASK  = ONE - 1;
    localparam longint SCALE = longint'(1) << (FRAC_BITS - 12);
    localparam longint L_LO  = (ONE * 5) / 100;
    localparam longint L_HI  = (ONE * 95) / 100;
    localparam longint THIRD = ONE / 3;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
    } t_pixel;

    longint hue_ofs;
    longint sat_mul;
    longint light_ofs;
    t_pixel expected_pixels[$];

    function automatic longint to_chan(longint v);
        longint c;
        c = (v * 255) >>> FRAC_BITS;
        return c > 255 ? 255 : c;
    endfunction

    function automatic longint seg_value(longint p, longint q, longint t);
        longint d;
        d = q - p;
        t = t & MASK;
        if (6 * t < ONE) return p + ((d * 6 * t) >>> FRAC_BITS);
        if (2 * t < ONE) return q;
        if (3 * t < 2 * ONE) return p + ((d * (4 * ONE - 6 * t)) >>> FRAC_BITS);
        return p;
    endfunction

    function automatic t_pixel adjust_pixel(t_pixel px);
        longint r, g, b, mx, mn, sum, delta, l, s, h, sixths, den, q, p;
        t_pixel res;
        r = longint'(px.red); g = longint'(px.green); b = longint'(px.blue);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        delta = mx - mn;
        l = (sum << FRAC_BITS) / 510;
        s = 0; h = 0;
        if (delta != 0) begin
            den = sum > 255 ? 510 - sum : sum;
            s = (delta << FRAC_BITS) / den;
            if (mx == r) sixths = g >= b ? g - b : 6 * delta - (b - g);
            else if (mx == g) sixths = 2 * delta + b - r;
            else sixths = 4 * delta + r - g;
            h = (sixths << FRAC_BITS) / (6 * delta);
        end
        h = (h + hue_ofs * SCALE) & MASK;
        s = (s * sat_mul) >>> 12;
        if (s > ONE) s = ONE;
        l = l + light_ofs * SCALE;
        if (l < L_LO) l = L_LO;
        if (l > L_HI) l = L_HI;
        if (s == 0) begin
            res.red = CW'(to_chan(l));
            res.green = res.red;
            res.blue = res.red;
            return res;
        end
        if (2 * l < ONE) q = (l * (ONE + s)) >>> FRAC_BITS;
        else q = l + s - ((l * s) >>> FRAC_BITS);
        p = 2 * l - q;
        res.red   = CW'(to_chan(seg_value(p, q, h + THIRD)));
        res.green = CW'(to_chan(seg_value(p, q, h)));
        res.blue  = CW'(to_chan(seg_value(p, q, h + ONE - THIRD)));
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            hue_ofs <= 0;
            sat_mul <= longint'(hsl_pkg::SAT_GAIN_RST);
            light_ofs <= 0;
            o_pending = 0;
        end else begin
            if (i_valid && !i_in_stall)
                expected_pixels.push_back(adjust_pixel({i_red, i_green, i_blue}));
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_red_out !== want.red)
                        report_mismatch("red", int'(i_red_out), int'(want.red));
                    if (i_green_out !== want.green)
                        report_mismatch("green", int'(i_green_out), int'(want.green));
                    if (i_blue_out !== want.blue)
                        report_mismatch("blue", int'(i_blue_out), int'(want.blue));
                end
            end
            o_pending = expected_pixels.size();
            if (i_cfg_we) begin
                case (hsl_pkg::t_cfg_idx'(i_cfg_idx))
                    hsl_pkg::CFG_HUE_SHIFT:
                        hue_ofs <= longint'(signed'(i_cfg_data[SW-1:0]));
                    hsl_pkg::CFG_SAT_GAIN:
                        sat_mul <= longint'(i_cfg_data);
                    hsl_pkg::CFG_LIGHT_SHIFT:
                        light_ofs <= longint'(signed'(i_cfg_data[SW-1:0]));
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: verif/hsl_color_adjust_tb.sv
// ----------------------------------------------------------------------------
// hsl_color_adjust_tb
// drives directed and random pixels through the adjuster under several
// register settings with random input gaps and random output stalls
// ----------------------------------------------------------------------------
module hsl_color_adjust_tb;

    localparam int LATENCY = 16 + 7;
    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [hsl_pkg::CHAN_W-1:0] i_red_in = '0, i_green_in = '0, i_blue_in = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [hsl_pkg::CHAN_W-1:0] o_red_out, o_green_out, o_blue_out;
    logic i_cfg_we = 1'b0;
    logic [hsl_pkg::CFG_IDX_W-1:0] i_cfg_idx = hsl_pkg::CFG_HUE_SHIFT;
    logic [hsl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    int errors, pending;
    int cycles = 0;
    bit hold_rx = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    hsl_color_adjust dut (.*);

    hsl_color_adjust_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_red(i_red_in), .i_green(i_green_in), .i_blue(i_blue_in),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_red_out(o_red_out),
        .i_green_out(o_green_out), .i_blue_out(o_blue_out), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_errors(errors),
        .o_pending(pending)
    );

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_rx) i_stall <= 1'b1;
        else if ($urandom_range(0, 3) == 0) i_stall <= ($urandom_range(0, 9) != 0);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("hsl_color_adjust_tb: FAIL");
            $finish;
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red_in <= r;
        i_green_in <= g;
        i_blue_in <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(hsl_pkg::t_cfg_idx idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic random_pixel();
        int k;
        logic [7:0] v;
        k = $urandom_range(0, 9);
        v = 8'($urandom);
        if (k == 0) begin
            send_pixel(v, v, v, 1);
        end else if (k == 1) begin
            send_pixel(8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                       v, 1);
        end else begin
            send_pixel(8'($urandom), 8'($urandom), v, 1);
        end
    endtask

    initial begin
        logic [15:0] hue_set[6] = '{16'h0000, 16'h1000, 16'h3000, 16'h0555, 16'h2ABC, 16'h1FFF};
        logic [15:0] gain_set[6] = '{16'd4096, 16'd0, 16'hFFFF, 16'd2048, 16'd1, 16'd9000};
        logic [15:0] light_set[6] =
            '{16'h0000, 16'h1000, 16'h3000, 16'h0333, 16'h3E00, 16'h2000};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners, greys, primaries, each hue sector
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 255, 255, 0);
        send_pixel(128, 128, 128, 0);
        send_pixel(255, 0, 0, 0);
        send_pixel(0, 255, 0, 0);
        send_pixel(0, 0, 255, 0);
        send_pixel(255, 255, 0, 0);
        send_pixel(0, 255, 255, 0);
        send_pixel(255, 0, 255, 0);
        send_pixel(200, 50, 100, 0);
        send_pixel(1, 0, 0, 0);
        send_pixel(255, 254, 255, 0);
        send_pixel(127, 128, 0, 0);
        send_pixel(170, 85, 0, 0);
        send_pixel(85, 170, 255, 0);
        send_pixel(10, 250, 240, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(hsl_pkg::CFG_HUE_SHIFT, hue_set[ph]);
            write_reg(hsl_pkg::CFG_SAT_GAIN, gain_set[ph]);
            write_reg(hsl_pkg::CFG_LIGHT_SHIFT, light_set[ph]);
            i_cfg_we <= 1'b0;
            for (int i = 0; i < 120; i++) begin
                if (ph == 2 && i == 20) begin
                    hold_rx <= 1'b1;
                    fork
                        begin
                            repeat (200) @(posedge i_clk);
                            hold_rx <= 1'b0;
                        end
                    join_none
                end
                random_pixel();
            end
            drain();
        end

        if (errors == 0) begin
            $display("hsl_color_adjust_tb: PASS");
        end else begin
            $display("hsl_color_adjust_tb: FAIL");
        end
        $finish;
    end
endmodule
